// File: design/awc_pkg.sv
// ----------------------------------------------------------------------------
// awc_pkg: shared types and codes of the associative write-back cache
// Command and result-kind codes plus the payload widths of both channels.
// ----------------------------------------------------------------------------
package awc_pkg;

  localparam int unsigned XLEN = 64;

  typedef logic [2:0]      cmd_t;
  typedef logic [2:0]      kind_t;
  typedef logic [XLEN-1:0] xword_t;

  localparam cmd_t CMD_READ       = 3'd0;
  localparam cmd_t CMD_WRITE      = 3'd1;
  localparam cmd_t CMD_FILL       = 3'd2;
  localparam cmd_t CMD_FLUSH_LINE = 3'd3;
  localparam cmd_t CMD_FLUSH_ALL  = 3'd4;
  localparam cmd_t CMD_REMOVE     = 3'd5;
  localparam cmd_t CMD_REMOVE_ALL = 3'd6;

  localparam kind_t KIND_READ    = 3'd0;
  localparam kind_t KIND_FILLREQ = 3'd1;
  localparam kind_t KIND_BUSWR   = 3'd2;
  localparam kind_t KIND_PASSRD  = 3'd3;
  localparam kind_t KIND_ACK     = 3'd4;

endpackage

// File: design/awc_if.sv
// ----------------------------------------------------------------------------
// awc_if: valid/ready channels of the associative write-back cache
// Request channel (awc_req_if) and result channel (awc_rsp_if).
// ----------------------------------------------------------------------------
interface awc_req_if;
  logic            valid;
  logic            ready;
  awc_pkg::cmd_t   command;
  awc_pkg::xword_t address;
  awc_pkg::xword_t write_data;
  logic            side_effects;
  logic            uncached;
  logic            uninitialized;

  modport source (output valid, command, address, write_data, side_effects,
                  uncached, uninitialized, input ready);
  modport sink   (input valid, command, address, write_data, side_effects,
                  uncached, uninitialized, output ready);
endinterface

interface awc_rsp_if;
  logic            valid;
  logic            ready;
  awc_pkg::kind_t  kind;
  awc_pkg::xword_t bus_address;
  awc_pkg::xword_t word;
  logic            bus_side_effects;
  logic            last;

  modport source (output valid, kind, bus_address, word, bus_side_effects, last,
                  input ready);
  modport sink   (input valid, kind, bus_address, word, bus_side_effects, last,
                  output ready);
endinterface

// File: design/assoc_writeback_cache.sv
// ----------------------------------------------------------------------------
// assoc_writeback_cache: fully associative write-back, write-allocate cache
// LINES lines of WORDS_PER_LINE words; data in a one-read one-write memory,
// tags/valid/dirty in flops, one small sequencer drives everything.
// ----------------------------------------------------------------------------
//  channel   dir  handshake     payload
//  in_i      in   valid/ready   command, address, write_data, side_effects,
//                               uncached, uninitialized
//  out_o     out  valid/ready   kind, bus_address, word, bus_side_effects, last
//  cfg       in   cfg_we_i      cfg_wdata_i -> device_start
//
// One word at a time. Each written-back word is a memory read, then an emit.
// Remove line zeroes WORDS_PER_LINE words, remove all LINES*WORDS_PER_LINE,
// one per cycle. After reset a clearing pass zeroes all LINES*WORDS_PER_LINE
// words before in_i goes ready. A stalled out_o holds the sequencer in its
// emitting state.
module assoc_writeback_cache #(
  parameter int unsigned LINES          = 8,
  parameter int unsigned WORDS_PER_LINE = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  awc_pkg::xword_t cfg_wdata_i,
  awc_req_if.sink         in_i,
  awc_rsp_if.source       out_o
);

  localparam int unsigned WPL   = WORDS_PER_LINE;
  localparam int unsigned DEPTH = LINES * WPL;
  localparam int unsigned LW    = (LINES > 1) ? $clog2(LINES) : 1;
  localparam int unsigned WW    = (WPL > 1) ? $clog2(WPL) : 1;
  localparam int unsigned IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned OFFW  = $clog2(WPL * 8);
  localparam int unsigned TAGW  = awc_pkg::XLEN - OFFW;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_LOOK, S_ACK, S_BUSW, S_PASSR, S_FIN, S_FINR,
    S_WB_RD, S_WB_EM, S_ALLOC, S_FREQ, S_FLA, S_FLN
  } state_e;

  typedef enum logic [1:0] {RET_ALLOC, RET_ACK, RET_FLA} wb_ret_e;
  typedef enum logic [1:0] {ZR_IDLE, ZR_ACK, ZR_FIN} clr_ret_e;

  state_e   state_q;
  wb_ret_e  wb_ret_q;
  clr_ret_e clr_ret_q;

  awc_pkg::xword_t dev_q;

  // latched request
  awc_pkg::cmd_t   it_cmd_q;
  awc_pkg::xword_t it_addr_q, it_data_q;
  logic            it_se_q, it_unc_q, it_uninit_q;

  logic [TAGW-1:0] tag_q [LINES];
  logic [LINES-1:0] valid_q, dirty_q;
  logic [LW-1:0]   vc_q;

  logic            fill_pend_q;
  logic [WW-1:0]   fc_q;
  logic [LW-1:0]   pl_q;
  logic            p_wr_q;
  awc_pkg::xword_t p_addr_q, p_data_q;

  logic [LW-1:0]   fin_line_q;
  logic            fin_wr_q;
  awc_pkg::xword_t fin_addr_q, fin_data_q;

  logic [LW-1:0]   wb_line_q, vic_q, fl_q;
  logic            wb_se_q;
  logic [WW-1:0]   w_q;
  logic [IW-1:0]   clr_q, clr_end_q;

  logic            out_valid_q, out_last_q, out_se_q;
  awc_pkg::kind_t  out_kind_q;
  awc_pkg::xword_t out_addr_q, out_word_q;

  awc_pkg::xword_t mem [DEPTH];
  awc_pkg::xword_t rdata_q;
  logic            mem_we, mem_re;
  logic [IW-1:0]   mem_widx, mem_ridx;
  awc_pkg::xword_t mem_wdata;

  function automatic logic [IW-1:0] idx_of(logic [LW-1:0] l, logic [WW-1:0] w);
    return IW'(32'(l) * WPL + 32'(w));
  endfunction

  // lookup of the latched address, plus the lowest free line
  logic [TAGW-1:0] key;
  logic            hit, free_found, is_dev, w_last;
  logic [LW-1:0]   hit_line, free_line, victim;
  logic [WW-1:0]   fin_word;
  logic            out_free;
  logic            emit_go;

  assign key      = it_addr_q[awc_pkg::XLEN-1:OFFW];
  assign is_dev   = it_addr_q >= dev_q;
  assign fin_word = WW'((fin_addr_q >> 3) & awc_pkg::XLEN'(WPL - 1));
  assign w_last   = w_q == WW'(WPL - 1);
  assign out_free = !out_valid_q || out_o.ready;
  assign victim   = free_found ? free_line : vc_q;

  always_comb begin
    hit        = 1'b0;
    hit_line   = '0;
    free_found = 1'b0;
    free_line  = '0;
    for (int i = LINES - 1; i >= 0; i--) begin
      if (valid_q[i] && tag_q[i] == key) begin
        hit      = 1'b1;
        hit_line = LW'(i);
      end
      if (!valid_q[i]) begin
        free_found = 1'b1;
        free_line  = LW'(i);
      end
    end
  end

  // a new word is loaded into the output register this cycle
  always_comb begin
    emit_go = 1'b0;
    unique case (state_q)
      S_ACK, S_BUSW, S_PASSR, S_FINR, S_WB_EM, S_FREQ: emit_go = out_free;
      S_FIN: emit_go = out_free && fin_wr_q;
      default: ;
    endcase
  end

  // data memory control
  always_comb begin
    mem_we    = 1'b0;
    mem_widx  = clr_q;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_ridx  = idx_of(wb_line_q, w_q);
    unique case (state_q)
      S_CLR: mem_we = 1'b1;
      S_LOOK: begin
        if (fill_pend_q && it_cmd_q == awc_pkg::CMD_FILL) begin
          mem_we    = 1'b1;
          mem_widx  = idx_of(pl_q, fc_q);
          mem_wdata = it_data_q;
        end
      end
      S_FIN: begin
        if (fin_wr_q) begin
          mem_we    = out_free;
          mem_widx  = idx_of(fin_line_q, fin_word);
          mem_wdata = fin_data_q;
        end else begin
          mem_re   = 1'b1;
          mem_ridx = idx_of(fin_line_q, fin_word);
        end
      end
      S_WB_RD: mem_re = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_widx] <= mem_wdata;
    if (mem_re) rdata_q <= mem[mem_ridx];
  end

  assign in_i.ready             = state_q == S_IDLE;
  assign out_o.valid            = out_valid_q;
  assign out_o.kind             = out_kind_q;
  assign out_o.bus_address      = out_addr_q;
  assign out_o.word             = out_word_q;
  assign out_o.bus_side_effects = out_se_q;
  assign out_o.last             = out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      wb_ret_q    <= RET_ACK;
      clr_ret_q   <= ZR_IDLE;
      dev_q       <= awc_pkg::xword_t'(1) << (awc_pkg::XLEN - 1);
      for (int i = 0; i < LINES; i++) tag_q[i] <= '0;
      valid_q     <= '0;
      dirty_q     <= '0;
      vc_q        <= '0;
      fill_pend_q <= 1'b0;
      fc_q        <= '0;
      pl_q        <= '0;
      w_q         <= '0;
      fl_q        <= '0;
      clr_q       <= '0;
      clr_end_q   <= IW'(DEPTH - 1);
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) dev_q <= cfg_wdata_i;
      if (emit_go) out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;

      unique case (state_q)
        S_CLR: begin
          if (clr_q == clr_end_q) begin
            unique case (clr_ret_q)
              ZR_IDLE: state_q <= S_IDLE;
              ZR_ACK:  state_q <= S_ACK;
              default: begin
                valid_q[fin_line_q] <= 1'b1;
                state_q <= S_FIN;
              end
            endcase
          end else begin
            clr_q <= clr_q + IW'(1);
          end
        end

        S_IDLE: begin
          if (in_i.valid) begin
            it_cmd_q    <= in_i.command;
            it_addr_q   <= in_i.address;
            it_data_q   <= in_i.write_data;
            it_se_q     <= in_i.side_effects;
            it_unc_q    <= in_i.uncached;
            it_uninit_q <= in_i.uninitialized;
            state_q     <= S_LOOK;
          end
        end

        S_LOOK: begin
          w_q <= '0;
          if (fill_pend_q) begin
            if (it_cmd_q != awc_pkg::CMD_FILL) begin
              state_q <= S_ACK;
            end else if (fc_q == WW'(WPL - 1)) begin
              fill_pend_q     <= 1'b0;
              fc_q            <= '0;
              valid_q[pl_q]   <= 1'b1;
              dirty_q[pl_q]   <= 1'b0;
              fin_line_q      <= pl_q;
              fin_wr_q        <= p_wr_q;
              fin_addr_q      <= p_addr_q;
              fin_data_q      <= p_data_q;
              state_q         <= S_FIN;
            end else begin
              // intermediate fill word: no result
              fc_q    <= fc_q + WW'(1);
              state_q <= S_IDLE;
            end
          end else begin
            case (it_cmd_q)
              awc_pkg::CMD_READ, awc_pkg::CMD_WRITE: begin
                fin_wr_q   <= it_cmd_q == awc_pkg::CMD_WRITE;
                fin_addr_q <= it_addr_q;
                fin_data_q <= it_data_q;
                if (!is_dev && hit) begin
                  fin_line_q <= hit_line;
                  state_q    <= S_FIN;
                end else if (!is_dev && !it_unc_q &&
                             (it_cmd_q == awc_pkg::CMD_WRITE || it_se_q)) begin
                  vic_q      <= victim;
                  fin_line_q <= victim;
                  if (!free_found)
                    vc_q <= (vc_q == LW'(LINES - 1)) ? '0 : vc_q + LW'(1);
                  if (dirty_q[victim]) begin
                    wb_line_q <= victim;
                    wb_se_q   <= it_se_q;
                    wb_ret_q  <= RET_ALLOC;
                    state_q   <= S_WB_RD;
                  end else begin
                    state_q <= S_ALLOC;
                  end
                end else if (it_cmd_q == awc_pkg::CMD_WRITE) begin
                  state_q <= S_BUSW;
                end else begin
                  state_q <= S_PASSR;
                end
              end
              awc_pkg::CMD_FLUSH_LINE: begin
                if (hit && dirty_q[hit_line]) begin
                  wb_line_q <= hit_line;
                  wb_se_q   <= 1'b1;
                  wb_ret_q  <= RET_ACK;
                  state_q   <= S_WB_RD;
                end else begin
                  state_q <= S_ACK;
                end
              end
              awc_pkg::CMD_FLUSH_ALL: begin
                fl_q    <= '0;
                state_q <= S_FLA;
              end
              awc_pkg::CMD_REMOVE: begin
                if (hit) begin
                  valid_q[hit_line] <= 1'b0;
                  dirty_q[hit_line] <= 1'b0;
                  tag_q[hit_line]   <= '0;
                  clr_q             <= idx_of(hit_line, '0);
                  clr_end_q         <= idx_of(hit_line, WW'(WPL - 1));
                  clr_ret_q         <= ZR_ACK;
                  state_q           <= S_CLR;
                end else begin
                  state_q <= S_ACK;
                end
              end
              awc_pkg::CMD_REMOVE_ALL: begin
                valid_q   <= '0;
                dirty_q   <= '0;
                for (int i = 0; i < LINES; i++) tag_q[i] <= '0;
                clr_q     <= '0;
                clr_end_q <= IW'(DEPTH - 1);
                clr_ret_q <= ZR_ACK;
                state_q   <= S_CLR;
              end
              default: state_q <= S_ACK;
            endcase
          end
        end

        S_ACK: begin
          if (out_free) begin
            out_kind_q  <= awc_pkg::KIND_ACK;
            out_addr_q  <= it_addr_q;
            out_word_q  <= '0;
            out_se_q    <= 1'b0;
            out_last_q  <= 1'b1;
            state_q     <= S_IDLE;
          end
        end

        S_BUSW, S_PASSR: begin
          if (out_free) begin
            out_kind_q  <= (state_q == S_BUSW) ? awc_pkg::KIND_BUSWR
                                               : awc_pkg::KIND_PASSRD;
            out_addr_q  <= it_addr_q;
            out_word_q  <= (state_q == S_BUSW) ? it_data_q : '0;
            out_se_q    <= it_se_q;
            out_last_q  <= 1'b1;
            state_q     <= S_IDLE;
          end
        end

        S_FIN: begin
          if (!fin_wr_q) begin
            state_q <= S_FINR;
          end else if (out_free) begin
            dirty_q[fin_line_q] <= 1'b1;
            out_kind_q  <= awc_pkg::KIND_ACK;
            out_addr_q  <= fin_addr_q;
            out_word_q  <= '0;
            out_se_q    <= 1'b0;
            out_last_q  <= 1'b1;
            state_q     <= S_IDLE;
          end
        end

        S_FINR: begin
          if (out_free) begin
            out_kind_q  <= awc_pkg::KIND_READ;
            out_addr_q  <= fin_addr_q;
            out_word_q  <= rdata_q;
            out_se_q    <= 1'b0;
            out_last_q  <= 1'b1;
            state_q     <= S_IDLE;
          end
        end

        S_WB_RD: state_q <= S_WB_EM;

        S_WB_EM: begin
          if (out_free) begin
            out_kind_q  <= awc_pkg::KIND_BUSWR;
            out_addr_q  <= {tag_q[wb_line_q], {OFFW{1'b0}}} |
                           (awc_pkg::XLEN'(w_q) << 3);
            out_word_q  <= rdata_q;
            out_se_q    <= wb_se_q;
            out_last_q  <= 1'b0;
            if (w_last) begin
              w_q                <= '0;
              dirty_q[wb_line_q] <= 1'b0;
              unique case (wb_ret_q)
                RET_ALLOC: state_q <= S_ALLOC;
                RET_ACK:   state_q <= S_ACK;
                default:   state_q <= S_FLN;
              endcase
            end else begin
              w_q     <= w_q + WW'(1);
              state_q <= S_WB_RD;
            end
          end
        end

        S_ALLOC: begin
          tag_q[vic_q]   <= key;
          valid_q[vic_q] <= 1'b0;
          dirty_q[vic_q] <= 1'b0;
          if (it_uninit_q) begin
            clr_q     <= idx_of(vic_q, '0);
            clr_end_q <= idx_of(vic_q, WW'(WPL - 1));
            clr_ret_q <= ZR_FIN;
            state_q   <= S_CLR;
          end else begin
            fill_pend_q <= 1'b1;
            fc_q        <= '0;
            pl_q        <= vic_q;
            p_wr_q      <= it_cmd_q == awc_pkg::CMD_WRITE;
            p_addr_q    <= it_addr_q;
            p_data_q    <= it_data_q;
            w_q         <= '0;
            state_q     <= S_FREQ;
          end
        end

        S_FREQ: begin
          if (out_free) begin
            out_kind_q  <= awc_pkg::KIND_FILLREQ;
            out_addr_q  <= {key, {OFFW{1'b0}}} | (awc_pkg::XLEN'(w_q) << 3);
            out_word_q  <= '0;
            out_se_q    <= it_se_q;
            out_last_q  <= w_last;
            w_q         <= w_q + WW'(1);
            if (w_last) state_q <= S_IDLE;
          end
        end

        S_FLA: begin
          if (valid_q[fl_q] && dirty_q[fl_q]) begin
            wb_line_q <= fl_q;
            wb_se_q   <= 1'b1;
            wb_ret_q  <= RET_FLA;
            w_q       <= '0;
            state_q   <= S_WB_RD;
          end else begin
            state_q <= S_FLN;
          end
        end

        S_FLN: begin
          if (fl_q == LW'(LINES - 1)) begin
            state_q <= S_ACK;
          end else begin
            fl_q    <= fl_q + LW'(1);
            state_q <= S_FLA;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// File: tb/sv/awc_tb_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// awc_tb_if: testbench-side notes for the cache channels
// The channel interfaces themselves come with the design; this file only
// holds the word type used by the scoreboard.
// ----------------------------------------------------------------------------
package awc_tb_pkg;

  typedef struct packed {
    awc_pkg::kind_t  kind;
    awc_pkg::xword_t addr;
    awc_pkg::xword_t data;
    logic            se;
    logic            last;
  } bus_word_t;
endpackage

// File: tb/sv/tb_assoc_writeback_cache.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_assoc_writeback_cache: self-checking bench of the write-back cache
// A shadow cache predicts every output word per accepted command; a
// scoreboard compares them in order. Directed corner cases, then random
// traffic with fill sequences, random request gaps and result back-pressure.
// ----------------------------------------------------------------------------
module tb_assoc_writeback_cache;

  localparam int NL = 8;
  localparam int NW = 4;
  localparam longint LIMIT = 1000000;
  localparam awc_pkg::cmd_t CMD_UNKNOWN = 3'd7;

  class cache_scoreboard;
    awc_pkg::xword_t       dev_start;
    awc_pkg::xword_t       tag [NL];
    bit                    vld [NL];
    bit                    dty [NL];
    awc_pkg::xword_t       mem [NL*NW];
    int                    victim;
    bit                    filling;
    int                    fill_cnt;
    awc_pkg::cmd_t         p_cmd;
    awc_pkg::xword_t       p_addr, p_data;
    int                    p_line;
    awc_tb_pkg::bus_word_t pending[$];
    int                    errors;
    int                    checked;

    function void clear();
      dev_start = 64'h8000_0000_0000_0000;
      foreach (tag[i]) begin tag[i] = 0; vld[i] = 0; dty[i] = 0; end
      foreach (mem[i]) mem[i] = 0;
      victim = 0; filling = 0; fill_cnt = 0; p_line = 0;
      p_cmd = awc_pkg::CMD_READ; p_addr = 0; p_data = 0;
    endfunction

    function void push(awc_pkg::kind_t k, awc_pkg::xword_t a, awc_pkg::xword_t d,
                       logic s);
      awc_tb_pkg::bus_word_t w;
      w.kind = k; w.addr = a; w.data = d; w.se = s; w.last = 0;
      pending.push_back(w);
    endfunction

    function int lookup(awc_pkg::xword_t a);
      for (int i = 0; i < NL; i++)
        if (vld[i] && tag[i] == {a[63:5], 5'b0}) return i;
      return -1;
    endfunction

    function void write_back(int l, logic s);
      if (!dty[l]) return;
      for (int w = 0; w < NW; w++)
        push(awc_pkg::KIND_BUSWR, tag[l] + 64'(8*w), mem[l*NW+w], s);
      dty[l] = 0;
    endfunction

    function void wipe(int l);
      vld[l] = 0; dty[l] = 0; tag[l] = 0;
      for (int w = 0; w < NW; w++) mem[l*NW+w] = 0;
    endfunction

    function void finish(int l, awc_pkg::cmd_t c, awc_pkg::xword_t a,
                         awc_pkg::xword_t d);
      int idx;
      idx = l*NW + int'(a[4:3]);
      if (c == awc_pkg::CMD_READ) push(awc_pkg::KIND_READ, a, mem[idx], 0);
      else begin
        mem[idx] = d; dty[l] = 1;
        push(awc_pkg::KIND_ACK, a, 0, 0);
      end
    endfunction

    // note an accepted command word
    function void note_command(awc_pkg::cmd_t c, awc_pkg::xword_t a,
                               awc_pkg::xword_t d, logic se, logic unc, logic uni);
      int l, v, n0;
      n0 = pending.size();
      if (filling) begin
        if (c != awc_pkg::CMD_FILL) push(awc_pkg::KIND_ACK, a, 0, 0);
        else begin
          mem[p_line*NW + fill_cnt] = d;
          fill_cnt++;
          if (fill_cnt >= NW) begin
            filling = 0; fill_cnt = 0;
            vld[p_line] = 1; dty[p_line] = 0;
            finish(p_line, p_cmd, p_addr, p_data);
          end
        end
      end else if (c == awc_pkg::CMD_READ || c == awc_pkg::CMD_WRITE) begin
        l = (a >= dev_start) ? -1 : lookup(a);
        if (l >= 0) finish(l, c, a, d);
        else if (a < dev_start && !unc && (c == awc_pkg::CMD_WRITE || se)) begin
          v = -1;
          for (int i = 0; i < NL; i++) if (v < 0 && !vld[i]) v = i;
          if (v < 0) begin v = victim; victim = (victim + 1) % NL; end
          write_back(v, se);
          vld[v] = 0; dty[v] = 0; tag[v] = {a[63:5], 5'b0};
          if (uni) begin
            for (int w = 0; w < NW; w++) mem[v*NW+w] = 0;
            vld[v] = 1;
            finish(v, c, a, d);
          end else begin
            for (int w = 0; w < NW; w++)
              push(awc_pkg::KIND_FILLREQ, tag[v] + 64'(8*w), 0, se);
            filling = 1; fill_cnt = 0;
            p_cmd = c; p_addr = a; p_data = d; p_line = v;
          end
        end else if (c == awc_pkg::CMD_WRITE) push(awc_pkg::KIND_BUSWR, a, d, se);
        else push(awc_pkg::KIND_PASSRD, a, 0, se);
      end else if (c == awc_pkg::CMD_FLUSH_LINE) begin
        l = lookup(a);
        if (l >= 0) write_back(l, 1);
        push(awc_pkg::KIND_ACK, a, 0, 0);
      end else if (c == awc_pkg::CMD_FLUSH_ALL) begin
        for (int i = 0; i < NL; i++) if (vld[i]) write_back(i, 1);
        push(awc_pkg::KIND_ACK, a, 0, 0);
      end else if (c == awc_pkg::CMD_REMOVE) begin
        l = lookup(a);
        if (l >= 0) wipe(l);
        push(awc_pkg::KIND_ACK, a, 0, 0);
      end else if (c == awc_pkg::CMD_REMOVE_ALL) begin
        for (int i = 0; i < NL; i++) wipe(i);
        push(awc_pkg::KIND_ACK, a, 0, 0);
      end else push(awc_pkg::KIND_ACK, a, 0, 0);
      if (pending.size() > n0) pending[pending.size()-1].last = 1;
    endfunction

    function void check_word(awc_tb_pkg::bus_word_t got);
      awc_tb_pkg::bus_word_t exp;
      checked++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected word %p", $realtime, got);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.kind !== exp.kind)
        $display("%0t: kind exp %0d got %0d", $realtime, exp.kind, got.kind);
      if (got.addr !== exp.addr)
        $display("%0t: address exp %h got %h", $realtime, exp.addr, got.addr);
      if (got.data !== exp.data)
        $display("%0t: word exp %h got %h", $realtime, exp.data, got.data);
      if (got.se !== exp.se)
        $display("%0t: side effects exp %b got %b", $realtime, exp.se, got.se);
      if (got.last !== exp.last)
        $display("%0t: last exp %b got %b", $realtime, exp.last, got.last);
      if (got !== exp) errors++;
    endfunction
  endclass

  logic            clk = 0;
  logic            rst_n = 0;
  logic            cfg_we = 0;
  awc_pkg::xword_t cfg_wdata = 0;
  longint          cycles = 0;
  int              stall_mode = 0;

  awc_req_if req ();
  awc_rsp_if rsp ();

  cache_scoreboard sb;

  assoc_writeback_cache dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_i       (req.sink),
    .out_o      (rsp.source)
  );

  always #5 clk = ~clk;

  function automatic int gap_len();
    if ($urandom_range(0, 2) == 0) return 0;
    if ($urandom_range(0, 15) == 0) return $urandom_range(10, 40);
    return $urandom_range(0, 3);
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL");
      $finish;
    end
  end

  // result side: random back-pressure, sampled at the edge
  int rdy_hold = 0;
  always @(posedge clk) begin
    if (rsp.valid && rsp.ready)
      sb.check_word({rsp.kind, rsp.bus_address, rsp.word, rsp.bus_side_effects,
                     rsp.last});
    if (rdy_hold > 0) rdy_hold <= rdy_hold - 1;
    else if (stall_mode == 0) rsp.ready <= 1;
    else begin
      rsp.ready <= ($urandom_range(0, 1) == 1);
      rdy_hold <= ($urandom_range(0, 20) == 0) ? $urandom_range(5, 30) : 0;
    end
  end

  task automatic send(awc_pkg::cmd_t c, awc_pkg::xword_t a, awc_pkg::xword_t d,
                      logic se, logic unc, logic uni);
    req.valid <= 1; req.command <= c; req.address <= a; req.write_data <= d;
    req.side_effects <= se; req.uncached <= unc; req.uninitialized <= uni;
    do @(posedge clk); while (!req.ready);
    sb.note_command(c, a, d, se, unc, uni);
    if (stall_mode != 0) begin
      int g;
      g = gap_len();
      if (g > 0) begin
        req.valid <= 0;
        repeat (g) @(posedge clk);
      end
    end
  endtask

  task automatic drain();
    req.valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic set_device_start(awc_pkg::xword_t v);
    drain();
    cfg_we <= 1; cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
    sb.dev_start = v;
  endtask

  task automatic fill_line();
    for (int w = 0; w < NW; w++)
      send(awc_pkg::CMD_FILL, {$urandom, $urandom}, {$urandom, $urandom}, 0, 0, 0);
  endtask

  // addresses from a small pool of lines so hits and evictions happen
  function automatic awc_pkg::xword_t pick_addr();
    awc_pkg::xword_t b;
    case ($urandom_range(0, 9))
      0: b = {$urandom, $urandom};
      1: b = 64'hFFFF_FFFF_FFFF_FFF8 - 64'($urandom_range(0, 15) * 8);
      default: b = 64'h1000 + 64'($urandom_range(0, 13)) * 32
                   + 64'($urandom_range(0, 3)) * 8 + 64'($urandom_range(0, 7));
    endcase
    return b;
  endfunction

  task automatic random_cmd();
    int              r;
    awc_pkg::cmd_t   c;
    awc_pkg::xword_t a;
    logic            se, unc, uni;
    r = $urandom_range(0, 99);
    a = pick_addr();
    se = 1'($urandom);
    unc = ($urandom_range(0, 7) == 0);
    uni = ($urandom_range(0, 3) == 0);
    if (r < 40) c = awc_pkg::CMD_READ;
    else if (r < 75) c = awc_pkg::CMD_WRITE;
    else if (r < 80) c = awc_pkg::CMD_FILL;
    else if (r < 86) c = awc_pkg::CMD_FLUSH_LINE;
    else if (r < 89) c = awc_pkg::CMD_FLUSH_ALL;
    else if (r < 95) c = awc_pkg::CMD_REMOVE;
    else if (r < 97) c = awc_pkg::CMD_REMOVE_ALL;
    else c = CMD_UNKNOWN;
    send(c, a, {$urandom, $urandom}, se, unc, uni);
    // a started fill is mostly answered properly, sometimes interrupted
    if (sb.filling) begin
      if ($urandom_range(0, 5) == 0)
        send(awc_pkg::cmd_t'($urandom_range(0, 7)), pick_addr(), {$urandom, $urandom},
             1'($urandom), 1'($urandom), 1'($urandom));
      while (sb.filling)
        send(awc_pkg::CMD_FILL, pick_addr(), {$urandom, $urandom}, 0, 0, 0);
    end
  endtask

  initial begin
    req.valid = 0; req.command = awc_pkg::CMD_READ; req.address = 0;
    req.write_data = 0; req.side_effects = 0; req.uncached = 0;
    req.uninitialized = 0;
    sb = new();
    sb.clear();
    repeat (11) @(posedge clk);
    rst_n <= 1;

    // directed
    send(awc_pkg::CMD_FILL, 64'h0, 64'h0, 0, 0, 0);
    send(CMD_UNKNOWN, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1, 1, 1);
    send(awc_pkg::CMD_READ, 64'h40, 0, 0, 0, 0);
    send(awc_pkg::CMD_READ, 64'hFFFF_FFFF_FFFF_FFF8, 0, 1, 0, 0);
    send(awc_pkg::CMD_WRITE, 64'h8000_0000_0000_0000, 64'hDEAD, 1, 0, 0);
    send(awc_pkg::CMD_WRITE, 64'h100, 64'hFFFF_FFFF_FFFF_FFFF, 1, 0, 0);
    send(awc_pkg::CMD_READ, 64'h120, 0, 0, 0, 0);
    fill_line();
    send(awc_pkg::CMD_READ, 64'h108, 0, 1, 0, 0);
    send(awc_pkg::CMD_WRITE, 64'h200, 64'h1234, 0, 0, 1);
    send(awc_pkg::CMD_READ, 64'h300, 0, 1, 1, 0);
    send(awc_pkg::CMD_READ, 64'h300, 0, 1, 0, 0);
    fill_line();
    send(awc_pkg::CMD_FLUSH_LINE, 64'h208, 0, 0, 0, 0);
    send(awc_pkg::CMD_FLUSH_LINE, 64'h9000, 0, 0, 0, 0);
    send(awc_pkg::CMD_FLUSH_ALL, 64'h77, 0, 0, 0, 0);
    send(awc_pkg::CMD_REMOVE, 64'h100, 0, 0, 0, 0);
    send(awc_pkg::CMD_REMOVE, 64'h9000, 0, 0, 0, 0);
    send(awc_pkg::CMD_REMOVE_ALL, 64'h5, 0, 0, 0, 0);

    set_device_start(64'h0);
    send(awc_pkg::CMD_WRITE, 64'h100, 64'h55, 1, 0, 1);
    send(awc_pkg::CMD_READ, 64'h0, 0, 1, 0, 0);
    set_device_start(64'hFFFF_FFFF_FFFF_FFFF);
    send(awc_pkg::CMD_WRITE, 64'hFFFF_FFFF_FFFF_FFF0, 64'hAA, 1, 0, 1);

    stall_mode = 1;
    for (int i = 0; i < 180; i++) begin
      if (i == 60) set_device_start(64'h1000 + 7*32);
      if (i == 120) set_device_start(64'h8000_0000_0000_0000);
      if (i == 90) drain();
      if (i == 140) stall_mode = 0;
      if (i == 160) stall_mode = 1;
      random_cmd();
    end
    drain();
    $display("ran %0d result words over directed corners and random traffic",
             sb.checked);
    $display("device_start swept across zero, all ones and mid values");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
